@@ hw/rtl/bqlp_pkg.sv @@
package bqlp_pkg;

  localparam int COEF_FRAC  = 30;
  localparam int SCALE_FRAC = 16;
  localparam int REG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 5;
  localparam int MUL_W      = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_SCALE = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    SRC_X  = 2'd0,
    SRC_D1 = 2'd1,
    SRC_D2 = 2'd2,
    SRC_W0 = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    CF_B0    = 3'd0,
    CF_B1    = 3'd1,
    CF_B2    = 3'd2,
    CF_A1    = 3'd3,
    CF_A2    = 3'd4,
    CF_SCALE = 3'd5
  } coef_sel_t;

  typedef enum logic [1:0] {
    ACC_KEEP  = 2'd0,
    ACC_CLR   = 2'd1,
    ACC_LOADX = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_PRE  = 2'd1,
    FIN_W0   = 2'd2,
    FIN_Y    = 2'd3
  } fin_t;

  typedef struct packed {
    logic              mul_en;
    src_t              src;
    coef_sel_t         coef;
    logic              hi;
    logic              sub;
    acc_op_t           acc;
    fin_t              fin;
    logic              jnp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_FILTER = 5'd5;
  localparam logic [STEP_W-1:0] LAST_STEP   = 5'd18;

  localparam ucode_t UC_NOP = '{
    mul_en: 1'b0, src: SRC_X, coef: CF_B0, hi: 1'b0, sub: 1'b0,
    acc: ACC_KEEP, fin: FIN_NONE, jnp: 1'b0, target: '0, last: 1'b0
  };

  function automatic ucode_t uc_mul(input src_t src, input coef_sel_t coef,
                                    input logic hi, input logic sub);
    ucode_t u;
    u        = UC_NOP;
    u.mul_en = 1'b1;
    u.src    = src;
    u.coef   = coef;
    u.hi     = hi;
    u.sub    = sub;
    return u;
  endfunction

  function automatic ucode_t bqlp_ucode(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = UC_NOP;
    unique case (step)
      5'd0: begin
        u.acc    = ACC_CLR;
        u.jnp    = 1'b1;
        u.target = STEP_FILTER;
      end
      5'd1:  u = uc_mul(SRC_X, CF_SCALE, 1'b0, 1'b0);
      5'd2:  u = uc_mul(SRC_X, CF_SCALE, 1'b1, 1'b0);
      5'd3:  u = UC_NOP;
      5'd4:  u.fin = FIN_PRE;
      5'd5: begin
        u     = uc_mul(SRC_D1, CF_A1, 1'b0, 1'b1);
        u.acc = ACC_LOADX;
      end
      5'd6:  u = uc_mul(SRC_D1, CF_A1, 1'b1, 1'b1);
      5'd7:  u = uc_mul(SRC_D2, CF_A2, 1'b0, 1'b1);
      5'd8:  u = uc_mul(SRC_D2, CF_A2, 1'b1, 1'b1);
      5'd9:  u = UC_NOP;
      5'd10: begin
        u.fin = FIN_W0;
        u.acc = ACC_CLR;
      end
      5'd11: u = uc_mul(SRC_W0, CF_B0, 1'b0, 1'b0);
      5'd12: u = uc_mul(SRC_W0, CF_B0, 1'b1, 1'b0);
      5'd13: u = uc_mul(SRC_D1, CF_B1, 1'b0, 1'b0);
      5'd14: u = uc_mul(SRC_D1, CF_B1, 1'b1, 1'b0);
      5'd15: u = uc_mul(SRC_D2, CF_B2, 1'b0, 1'b0);
      5'd16: u = uc_mul(SRC_D2, CF_B2, 1'b1, 1'b0);
      5'd17: u = UC_NOP;
      5'd18: begin
        u.fin  = FIN_Y;
        u.last = 1'b1;
      end
      default: u = UC_NOP;
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/bqlp_if.sv @@
interface bqlp_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output req_type, output sample_in, input ready);
  modport sink   (input valid, input req_type, input sample_in, output ready);
endinterface

interface bqlp_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_out;
  logic                           state_overflow;

  modport source (output valid, output filtered_out, output state_overflow, input ready);
  modport sink   (input valid, input filtered_out, input state_overflow, output ready);
endinterface

@@ hw/rtl/biquad_lowpass_df2_top.sv @@
// Second-order low-pass biquad, direct form II, fixed point.
// sample_chan (valid/ready) takes one request: req_type and a signed Q16.16
// sample. req_type 1 first preloads both delays with sample * reset_scale.
// result_chan (valid/ready) returns one filtered, saturated sample per request
// plus state_overflow, set when the internal value left the delay range and
// the input sample took its place.
// Configuration: cfg_we with cfg_index 0..5 writes b0, b1, b2, a1, a2 and
// reset_scale; any such write clears both delays. Write only while idle.
// Timing: a request runs through a 19-step microprogram (15 steps without
// preload) on one 33x33 multiplier that issues one partial product per multiply
// step; each product is registered, then added into the accumulator. The result
// is registered at the last step, and a new request is taken only once the
// sequencer is back in idle.
// Reset (rst, synchronous) restores the default coefficients (b0 = 1.0,
// reset_scale = 1.0, others zero), clears the delays and drops result_chan.valid.
// If the receiver stalls with a result still held, the sequencer waits on its
// last step; sample_chan.ready stays low until the pending result is taken.
module biquad_lowpass_df2_top #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int STATE_WIDTH  = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  bqlp_in_if.sink                           sample_chan,
  bqlp_out_if.source                        result_chan,
  input  logic                              cfg_we,
  input  logic [bqlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqlp_pkg::REG_W-1:0]       cfg_data
);
  import bqlp_pkg::*;

  localparam int OPW   = (STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH;
  localparam int ACC_W = OPW + 36;
  localparam int EXT_W = 65;

  localparam logic signed [ACC_W-1:0] HALF_COEF =
    {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF_SCALE =
    {{(ACC_W-SCALE_FRAC){1'b0}}, 1'b1, {(SCALE_FRAC-1){1'b0}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  function automatic logic fits_state(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-STATE_WIDTH:0] top;
    top = v[ACC_W-1:STATE_WIDTH-1];
    return (&top) | ~(|top);
  endfunction

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [ACC_W-1:0] v);
    logic signed [STATE_WIDTH-1:0] r;
    if (fits_state(v)) begin
      r = v[STATE_WIDTH-1:0];
    end else begin
      r = v[ACC_W-1] ? STATE_MIN : STATE_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SAMPLE_WIDTH:0]    top;
    logic signed [SAMPLE_WIDTH-1:0] r;
    top = v[ACC_W-1:SAMPLE_WIDTH-1];
    if ((&top) | ~(|top)) begin
      r = v[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return r;
  endfunction

  seq_state_t                     state, state_next;
  logic [STEP_W-1:0]              step, step_next;
  ucode_t                         uc;
  logic                           running;
  logic                           advance;

  logic [REG_W-1:0]               coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, reset_scale;
  logic                           cfg_hit;

  logic                           pre;
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [STATE_WIDTH-1:0]  d1, d2, w0;
  logic                           ovf;

  logic signed [OPW-1:0]          opnd;
  logic signed [EXT_W-1:0]        opnd_ext;
  logic signed [MUL_W-1:0]        mul_a, mul_b;
  logic signed [2*MUL_W-1:0]      prod;
  logic                           prod_en, prod_hi, prod_sub;

  logic signed [ACC_W-1:0]        acc, acc_next, acc_base, term;
  logic signed [ACC_W-1:0]        rnd_coef, rnd_scale;

  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_y;
  logic                           out_ovf;

  assign running = (state == ST_RUN);
  assign uc      = bqlp_ucode(step);
  assign advance = !(uc.fin == FIN_Y && out_valid && !result_chan.ready);
  assign cfg_hit = cfg_we && (cfg_index <= REG_SCALE);

  assign sample_chan.ready          = (state == ST_IDLE);
  assign result_chan.valid          = out_valid;
  assign result_chan.filtered_out   = out_y;
  assign result_chan.state_overflow = out_ovf;

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (sample_chan.valid) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (uc.last) begin
            state_next = ST_IDLE;
          end else if (uc.jnp && !pre) begin
            step_next = uc.target;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_chan.valid && sample_chan.ready) begin
      x_reg <= sample_chan.sample_in;
      pre   <= sample_chan.req_type;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0     <= 32'h4000_0000;
      coef_b1     <= '0;
      coef_b2     <= '0;
      coef_a1     <= '0;
      coef_a2     <= '0;
      reset_scale <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:    coef_b0     <= cfg_data;
        REG_B1:    coef_b1     <= cfg_data;
        REG_B2:    coef_b2     <= cfg_data;
        REG_A1:    coef_a1     <= cfg_data;
        REG_A2:    coef_a2     <= cfg_data;
        REG_SCALE: reset_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier: one 33x33 partial product per step
  always_comb begin
    unique case (uc.src)
      SRC_X:   opnd = OPW'(x_reg);
      SRC_D1:  opnd = OPW'(d1);
      SRC_D2:  opnd = OPW'(d2);
      SRC_W0:  opnd = OPW'(w0);
      default: opnd = '0;
    endcase
    opnd_ext = EXT_W'(opnd);
    mul_a    = uc.hi ? opnd_ext[EXT_W-1:32] : {1'b0, opnd_ext[31:0]};
    unique case (uc.coef)
      CF_B0:    mul_b = {coef_b0[REG_W-1], coef_b0};
      CF_B1:    mul_b = {coef_b1[REG_W-1], coef_b1};
      CF_B2:    mul_b = {coef_b2[REG_W-1], coef_b2};
      CF_A1:    mul_b = {coef_a1[REG_W-1], coef_a1};
      CF_A2:    mul_b = {coef_a2[REG_W-1], coef_a2};
      CF_SCALE: mul_b = {1'b0, reset_scale};
      default:  mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_en <= 1'b0;
    end else begin
      prod_en <= running && uc.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_hi  <= uc.hi;
    prod_sub <= uc.sub;
  end

  // accumulator
  always_comb begin
    term = prod_hi ? (ACC_W'(prod) <<< 32) : ACC_W'(prod);
    acc_base = acc;
    if (running) begin
      unique case (uc.acc)
        ACC_CLR:   acc_base = '0;
        ACC_LOADX: acc_base = ACC_W'(x_reg) <<< COEF_FRAC;
        ACC_KEEP:  acc_base = acc;
        default:   acc_base = acc;
      endcase
    end
    acc_next = acc_base;
    if (prod_en) begin
      acc_next = prod_sub ? (acc_base - term) : (acc_base + term);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  assign rnd_coef  = (acc + HALF_COEF) >>> COEF_FRAC;
  assign rnd_scale = (acc + HALF_SCALE) >>> SCALE_FRAC;

  // delays and internal value
  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (cfg_hit) begin
      d1 <= '0;
      d2 <= '0;
    end else if (running && advance) begin
      unique case (uc.fin)
        FIN_PRE: begin
          d1 <= sat_state(rnd_scale);
          d2 <= sat_state(rnd_scale);
        end
        FIN_Y: begin
          d2 <= d1;
          d1 <= w0;
        end
        FIN_W0, FIN_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (running && uc.fin == FIN_W0) begin
      if (fits_state(rnd_coef)) begin
        w0  <= rnd_coef[STATE_WIDTH-1:0];
        ovf <= 1'b0;
      end else begin
        w0  <= sat_state(ACC_W'(x_reg));
        ovf <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (running && uc.fin == FIN_Y && advance) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (running && uc.fin == FIN_Y && advance) begin
      out_y   <= sat_sample(rnd_coef);
      out_ovf <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_prod_from_run: assert property (@(posedge clk) disable iff (rst)
    prod_en |-> $past(state == ST_RUN))
    else $error("partial product issued outside a request");

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    running |-> (step <= LAST_STEP))
    else $error("step counter ran past the microprogram");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (running && uc.fin == FIN_Y && advance) |=> (out_valid && state == ST_IDLE))
    else $error("final step did not post a result");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (d1 == '0 && d2 == '0))
    else $error("register write did not clear the delays");
`endif

endmodule

@@ bench/tb_biquad_lowpass_df2_top.sv @@
`timescale 1ns / 100ps

module tb_biquad_lowpass_df2_top;
  import bqlp_pkg::*;

  localparam int SAMPLE_W    = 32;
  localparam int STATE_W     = 48;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int SEGMENT     = 48;

  localparam logic REQ_FILTER  = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  typedef logic signed [127:0] acc_t;

  localparam acc_t STATE_HI = (acc_t'(1) <<< (STATE_W - 1)) - 1;
  localparam acc_t STATE_LO = -(acc_t'(1) <<< (STATE_W - 1));
  localparam acc_t OUT_HI   = (acc_t'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam acc_t OUT_LO   = -(acc_t'(1) <<< (SAMPLE_W - 1));

  typedef enum logic [1:0] {
    ROW_FILTER,
    ROW_PRELOAD,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     value;
    logic                 typed;
    logic [SAMPLE_W-1:0]  y;
    logic                 ovf;
  } stim_row_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y;
    logic                ovf;
  } biquad_out_t;

  localparam int N_DIRECTED = 35;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_FILTER,  REG_B0,      32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_FILTER,  REG_B0,      32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_FILTER,  REG_B0,      32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_PRELOAD, REG_B0,      32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_PRELOAD, REG_B0,      32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_FILTER,  REG_B0,      32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
    '{ROW_PRELOAD, REG_B0,      32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_FILTER,  REG_B0,      32'h5555_5555, 1'b1, 32'h5555_5555, 1'b0},
    '{ROW_FILTER,  REG_B0,      32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1'b0},
    '{ROW_WRITE,   REG_SCALE,   32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_A1,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_A2,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_B1,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_B2,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_B0,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_PRELOAD, REG_B0,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_PRELOAD, REG_B0,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   IDX_SPARE_A, 32'h1234_5678, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   IDX_SPARE_B, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_SCALE,   32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_B0,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_A1,      32'h4000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_PRELOAD, REG_B0,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_A2,      32'hC000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,   REG_B2,      32'h4000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_PRELOAD, REG_B0,      32'h1234_5678, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'hEDCB_A988, 1'b0, 32'h0,         1'b0},
    '{ROW_FILTER,  REG_B0,      32'h0000_0000, 1'b0, 32'h0,         1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  bqlp_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) sample_chan ();
  bqlp_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) result_chan ();

  biquad_lowpass_df2_top #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH (STATE_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .sample_chan(sample_chan),
    .result_chan(result_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  logic signed [REG_W-1:0]   tap_b0, tap_b1, tap_b2, fb_a1, fb_a2;
  logic [REG_W-1:0]          preload_scale;
  logic signed [STATE_W-1:0] z1, z2;

  biquad_out_t expected_out [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;
  logic        stall_armed;
  logic        stall_done;
  int unsigned quiet_cycles;
  int          mismatches;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic acc_t round_shift(input acc_t v, input int s);
    return (v + (acc_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic acc_t clamp(input acc_t v, input acc_t lo, input acc_t hi,
                                 output logic clipped);
    clipped = (v < lo) || (v > hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic run_biquad(input logic rt, input logic signed [SAMPLE_W-1:0] x,
                            output biquad_out_t res);
    acc_t acc, w0, pre;
    logic clipped, ovf;
    if (rt == REQ_PRELOAD) begin
      pre = clamp(round_shift(acc_t'(x) * acc_t'(preload_scale), SCALE_FRAC),
                  STATE_LO, STATE_HI, clipped);
      z1  = pre[STATE_W-1:0];
      z2  = pre[STATE_W-1:0];
    end
    acc = (acc_t'(x) <<< COEF_FRAC) - acc_t'(fb_a1) * acc_t'(z1)
          - acc_t'(fb_a2) * acc_t'(z2);
    w0  = clamp(round_shift(acc, COEF_FRAC), STATE_LO, STATE_HI, ovf);
    if (ovf) begin
      w0 = acc_t'(x);
    end
    acc = acc_t'(tap_b0) * w0 + acc_t'(tap_b1) * acc_t'(z1) + acc_t'(tap_b2) * acc_t'(z2);
    acc = clamp(round_shift(acc, COEF_FRAC), OUT_LO, OUT_HI, clipped);
    res.y   = acc[SAMPLE_W-1:0];
    res.ovf = ovf;
    z2 = z1;
    z1 = w0[STATE_W-1:0];
  endtask

  task automatic send_request(input logic rt, input logic [SAMPLE_W-1:0] x,
                              input logic typed, input biquad_out_t typed_out);
    biquad_out_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_chan.valid <= 1'b0;
      @(negedge clk);
    end
    sample_chan.valid     <= 1'b1;
    sample_chan.req_type  <= rt;
    sample_chan.sample_in <= x;
    do @(posedge clk); while (!sample_chan.ready);
    run_biquad(rt, x, res);
    expected_out.push_back(typed ? typed_out : res);
  endtask

  task automatic settle_filter;
    @(negedge clk);
    sample_chan.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    logic known;
    known = 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_B0:    tap_b0 = data;
      REG_B1:    tap_b1 = data;
      REG_B2:    tap_b2 = data;
      REG_A1:    fb_a1 = data;
      REG_A2:    fb_a2 = data;
      REG_SCALE: preload_scale = data;
      default:   known = 1'b0;
    endcase
    if (known) begin
      z1 = '0;
      z2 = '0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs;
    logic [REG_W-1:0] regs [6];
    int unsigned      r, b, mag;
    int               a2;
    longint           lim, gain_sum;
    r = $urandom_range(99);
    if (r < 65) begin
      // stable low-pass shape with random corner and damping
      b   = $urandom_range(1 << 28);
      a2  = int'($urandom_range(32'h5C00_0000)) - (1 << 29);
      lim = ((longint'(1) << 30) + a2) * 15 / 16;
      mag = $urandom_range(32'(lim));
      regs[REG_B0]  = b;
      regs[REG_B1]  = 2 * b;
      regs[REG_B2]  = b;
      regs[REG_A2]  = a2;
      regs[REG_A1]  = ($urandom_range(3) == 0) ? mag : -mag;
      gain_sum      = 4 * longint'(b);
      regs[REG_SCALE] = (gain_sum == 0 || ((longint'(1) << 46) / gain_sum) > 64'hFFFF_FFFF)
                        ? 32'hFFFF_FFFF : 32'((longint'(1) << 46) / gain_sum);
    end else if (r < 85) begin
      foreach (regs[i]) regs[i] = $urandom();
    end else begin
      foreach (regs[i]) begin
        case ($urandom_range(3))
          0:       regs[i] = 32'h8000_0000;
          1:       regs[i] = 32'h7FFF_FFFF;
          2:       regs[i] = 32'h0000_0000;
          default: regs[i] = 32'h4000_0000;
        endcase
      end
    end
    for (int i = 0; i < 6; i++) begin
      write_reg(CFG_IDX_W'(i), regs[i]);
    end
    if ($urandom_range(4) == 0) begin
      write_reg($urandom_range(1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom());
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    logic [SAMPLE_W-1:0] level;
    int unsigned         r;
    level = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i % SEGMENT == 0) begin
        settle_filter();
        load_coefs();
      end
      r = $urandom_range(99);
      if (r < 60) begin
        level = level + $urandom_range(1 << 20) - (1 << 19);
      end else if (r < 80) begin
        level = $urandom();
      end else if (r < 90) begin
        case ($urandom_range(3))
          0:       level = 32'h7FFF_FFFF;
          1:       level = 32'h8000_0000;
          2:       level = 32'hFFFF_FFFF;
          default: level = 32'h0000_0000;
        endcase
      end else begin
        level = $urandom_range(511) - 256;
      end
      send_request(($urandom_range(99) < 12) ? REQ_PRELOAD : REQ_FILTER, level, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left        <= stall_left - 1;
      result_chan.ready <= 1'b0;
    end else if (stall_armed && !stall_done) begin
      stall_left        <= LONG_HOLD;
      stall_done        <= 1'b1;
      result_chan.ready <= 1'b0;
    end else begin
      result_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    biquad_out_t want;
    if (!rst && result_chan.valid && result_chan.ready) begin
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected result: actual y=%h ovf=%b", $time,
                 result_chan.filtered_out, result_chan.state_overflow);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (result_chan.filtered_out !== want.y) begin
          $display("%0t: filtered_out expected %h actual %h", $time, want.y,
                   result_chan.filtered_out);
          mismatches++;
        end
        if (result_chan.state_overflow !== want.ovf) begin
          $display("%0t: state_overflow expected %b actual %b", $time, want.ovf,
                   result_chan.state_overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_chan.valid && sample_chan.ready) || (result_chan.valid && result_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    sample_chan.valid     = 1'b0;
    sample_chan.req_type  = REQ_FILTER;
    sample_chan.sample_in = '0;
    result_chan.ready     = 1'b0;
    stall_left            = 0;
    stall_armed           = 1'b0;
    stall_done            = 1'b0;
    quiet_cycles          = 0;
    mismatches            = 0;
    tap_b0                = 32'h4000_0000;
    tap_b1                = '0;
    tap_b2                = '0;
    fb_a1                 = '0;
    fb_a2                 = '0;
    preload_scale         = 32'h0001_0000;
    z1                    = '0;
    z2                    = '0;
    send_idle_pct         = 20;
    recv_idle_pct         = 81;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle_filter();
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      end else begin
        send_request((DIRECTED[i].kind == ROW_PRELOAD) ? REQ_PRELOAD : REQ_FILTER,
                     DIRECTED[i].value, DIRECTED[i].typed,
                     biquad_out_t'{DIRECTED[i].y, DIRECTED[i].ovf});
      end
    end

    run_phase(145);
    send_idle_pct = 81;
    recv_idle_pct = 20;
    run_phase(145);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side so the block backs up onto its request side
    stall_armed = 1'b1;
    run_phase(145);

    settle_filter();
    repeat (24) @(posedge clk);

    if (expected_out.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_out.size());
    end
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bqlp_pkg.sv
hw/rtl/bqlp_if.sv
hw/rtl/biquad_lowpass_df2_top.sv
bench/tb_biquad_lowpass_df2_top.sv
